>>> hw/rtl/mandelbrot_escape_time_unit_defines.svh
// Assertion macros for the escape-time unit.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define MET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MET_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MET_ASSERT(lbl, prop, msg)
`define MET_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> hw/rtl/met_pkg.sv
package met_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 28;

  localparam int PIX_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = PIX_W + 1;
  localparam int NUM_W     = PIX_W + 2;
  localparam int REM_W     = PIX_W;
  localparam int QUO_W     = FRAC_BITS + 2;
  localparam int WORD_W    = FRAC_BITS + 4;
  localparam int DIV_STEPS = NUM_W + FRAC_BITS;
  localparam int ITER_W    = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd2;

  localparam logic [DIM_W-1:0]  RST_NUM_COLS = DIM_W'(640);
  localparam logic [DIM_W-1:0]  RST_NUM_ROWS = DIM_W'(480);
  localparam logic [ITER_W-1:0] RST_MAX_ITER = ITER_W'(256);

  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  localparam logic signed [WORD_W-1:0] FP_ONE = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] FP_TWO = WORD_W'(1) << (FRAC_BITS + 1);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } met_lane_t;

  typedef struct packed {
    met_lane_t re;
    met_lane_t im;
  } met_pair_t;

  typedef struct packed {
    logic active;
    logic done;
  } met_iter_stat_t;

endpackage

>>> hw/rtl/met_pixel_if.sv
interface met_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [met_pkg::PIX_W-1:0]  pixel_row;
  logic [met_pkg::PIX_W-1:0]  pixel_col;

  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink (input valid, input pixel_row, input pixel_col, output ready);
endinterface

>>> hw/rtl/met_result_if.sv
interface met_result_if;
  logic                        valid;
  logic                        ready;
  logic [met_pkg::ITER_W-1:0]  iter_count;

  modport source (output valid, output iter_count, input ready);
  modport sink (input valid, input iter_count, output ready);
endinterface

>>> hw/rtl/met_div_cell.sv
// One restoring division step for both coordinates.
module met_div_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  met_pkg::met_pair_t        pair_i,
  input  logic [met_pkg::REM_W-1:0] den_re_i,
  input  logic [met_pkg::REM_W-1:0] den_im_i,
  output logic                      valid_o,
  output met_pkg::met_pair_t        pair_o
);

  function automatic met_pkg::met_lane_t lane_step(met_pkg::met_lane_t l,
                                                   logic [met_pkg::REM_W-1:0] den);
    logic [met_pkg::REM_W:0] trial;
    logic [met_pkg::REM_W:0] diff;
    logic                    ge;
    met_pkg::met_lane_t      n;
    trial = {l.rem, l.num[met_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
    n.rem = ge ? diff[met_pkg::REM_W-1:0] : trial[met_pkg::REM_W-1:0];
    n.num = {l.num[met_pkg::NUM_W-2:0], 1'b0};
    n.quo = {l.quo[met_pkg::QUO_W-2:0], ge};
    return n;
  endfunction

  met_pkg::met_pair_t pair_d;

  always_comb begin
    pair_d.re = lane_step(pair_i.re, den_re_i);
    pair_d.im = lane_step(pair_i.im, den_im_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_o <= pair_d;
  end

endmodule

>>> hw/rtl/met_iter.sv
// z = z*z + c iteration with escape test; each iteration passes through the multiply and check states.
module met_iter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [met_pkg::WORD_W-1:0] cre_i,
  input  logic signed [met_pkg::WORD_W-1:0] cim_i,
  input  logic [met_pkg::ITER_W-1:0]        max_iter_i,
  input  logic                              take_i,
  output met_pkg::met_iter_stat_t           stat_o,
  output logic [met_pkg::ITER_W-1:0]        count_o
);

  localparam int W = met_pkg::WORD_W;
  localparam int F = met_pkg::FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic signed [W-1:0] FP_NEG_TWO = -met_pkg::FP_TWO;
  localparam logic signed [W:0]   FP_FOUR    = (W+1)'(1) << (F + 2);

  logic [1:0]                     state_q, state_d;
  logic [met_pkg::ITER_W-1:0]     iter_q, iter_d;
  logic signed [W-1:0]            re_q, re_d, im_q, im_d;
  logic signed [W-1:0]            cre_q, cim_q;
  logic signed [W-1:0]            rr_q, ii_q, ri_q;
  logic signed [2*W-1:0]          prod_rr, prod_ii, prod_ri;
  logic signed [W:0]              mag;
  logic                           esc;

  assign prod_rr = re_q * re_q;
  assign prod_ii = im_q * im_q;
  assign prod_ri = re_q * im_q;

  assign mag = $signed({rr_q[W-1], rr_q}) + $signed({ii_q[W-1], ii_q});
  assign esc = (re_q >= met_pkg::FP_TWO) || (re_q <= FP_NEG_TWO) ||
               (im_q >= met_pkg::FP_TWO) || (im_q <= FP_NEG_TWO) ||
               (mag >= FP_FOUR);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    re_d    = re_q;
    im_d    = im_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_MUL;
          iter_d  = '0;
          re_d    = '0;
          im_d    = '0;
        end
      end
      ST_MUL: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if ((iter_q == max_iter_i) || esc) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
          re_d    = rr_q - ii_q + cre_q;
          im_d    = ri_q + cim_q;
          iter_d  = iter_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    re_q   <= re_d;
    im_q   <= im_d;
    if (state_q == ST_IDLE && start_i) begin
      cre_q <= cre_i;
      cim_q <= cim_i;
    end
    if (state_q == ST_MUL) begin
      rr_q <= prod_rr[F +: W];
      ii_q <= prod_ii[F +: W];
      ri_q <= prod_ri[F-1 +: W];
    end
  end

  assign stat_o.active = (state_q != ST_IDLE);
  assign stat_o.done   = (state_q == ST_DONE);
  assign count_o       = iter_q;

endmodule

>>> hw/rtl/mandelbrot_escape_time_unit.sv
// The pixel-to-plane mapping runs through a row of 42 division cells (one bit each).
// Each iteration passes through the multiply and escape-check states of the shared multiply/escape unit.
// One item at a time: the next item is taken only after
// the result is registered; a result still waiting on ready holds the unit in its place.
// Reset (async, active low) clears control state; registers return to 640/480/256.
`include "mandelbrot_escape_time_unit_defines.svh"

module mandelbrot_escape_time_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [met_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [met_pkg::CFG_DATA_W-1:0] cfg_data_i,
  met_pixel_if.sink                      pixel_i,
  met_result_if.source                   result_o
);

  localparam int N = met_pkg::DIV_STEPS;

  logic [met_pkg::DIM_W-1:0]  num_cols_q, num_rows_q;
  logic [met_pkg::ITER_W-1:0] max_iter_q;

  logic [met_pkg::DIM_W-1:0]  cols_c, rows_c, cols_m1, rows_m1;
  logic [met_pkg::PIX_W-1:0]  den_col, den_row, col_c, row_c;

  logic                       busy_q;
  logic                       accept;
  logic [N:0]                 vld;
  met_pkg::met_pair_t         pair [N+1];

  logic signed [met_pkg::WORD_W-1:0] cre, cim;
  met_pkg::met_iter_stat_t    ist;
  logic [met_pkg::ITER_W-1:0] icount;
  logic                       take;
  logic                       out_valid_q;
  logic [met_pkg::ITER_W-1:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= met_pkg::RST_NUM_COLS;
      num_rows_q <= met_pkg::RST_NUM_ROWS;
      max_iter_q <= met_pkg::RST_MAX_ITER;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        met_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data_i;
        met_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data_i;
        met_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data_i[met_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_cols_q < met_pkg::DIM_MIN) begin
      cols_c = met_pkg::DIM_MIN;
    end else if (num_cols_q > met_pkg::DIM_MAX) begin
      cols_c = met_pkg::DIM_MAX;
    end else begin
      cols_c = num_cols_q;
    end
    if (num_rows_q < met_pkg::DIM_MIN) begin
      rows_c = met_pkg::DIM_MIN;
    end else if (num_rows_q > met_pkg::DIM_MAX) begin
      rows_c = met_pkg::DIM_MAX;
    end else begin
      rows_c = num_rows_q;
    end
  end

  assign cols_m1 = cols_c - 1'b1;
  assign rows_m1 = rows_c - 1'b1;
  assign den_col = cols_m1[met_pkg::PIX_W-1:0];
  assign den_row = rows_m1[met_pkg::PIX_W-1:0];

  assign col_c = (pixel_i.pixel_col > den_col) ? den_col : pixel_i.pixel_col;
  assign row_c = (pixel_i.pixel_row > den_row) ? den_row : pixel_i.pixel_row;

  assign pixel_i.ready = !busy_q;
  assign accept        = pixel_i.valid && !busy_q;

  // numerators 3*col and 2*row enter the first cell
  assign vld[0]          = accept;
  assign pair[0].re.rem  = '0;
  assign pair[0].re.num  = {1'b0, col_c, 1'b0} + {2'b00, col_c};
  assign pair[0].re.quo  = '0;
  assign pair[0].im.rem  = '0;
  assign pair[0].im.num  = {1'b0, row_c, 1'b0};
  assign pair[0].im.quo  = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    met_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (vld[g]),
      .pair_i   (pair[g]),
      .den_re_i (den_col),
      .den_im_i (den_row),
      .valid_o  (vld[g+1]),
      .pair_o   (pair[g+1])
    );
  end

  assign cre = $signed({2'b00, pair[N].re.quo}) - met_pkg::FP_TWO;
  assign cim = $signed({2'b00, pair[N].im.quo}) - met_pkg::FP_ONE;

  met_iter u_iter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (vld[N]),
    .cre_i      (cre),
    .cim_i      (cim),
    .max_iter_i (max_iter_q),
    .take_i     (take),
    .stat_o     (ist),
    .count_o    (icount)
  );

  assign take = ist.done && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (take) begin
        busy_q <= 1'b0;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_count_q <= icount;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.iter_count = out_count_q;

  `MET_ASSERT(a_one_in_flight, $onehot0({vld[N:1], ist.active}), "more than one item in flight")
  `MET_ASSERT(a_busy_after_accept, accept |=> busy_q, "accepted item did not mark unit busy")
  `MET_ASSERT(a_result_on_take, take |=> (out_valid_q && out_count_q == $past(icount)), "result not registered")
  `MET_ASSERT_NEVER(a_ready_while_iter, ist.active && pixel_i.ready, "ready while iterating")

endmodule
